>>> hdl/lecr_pkg.sv
// Package for the line-edit command router: character codes, command
// letter slots, queue entry type and the letter-to-slot function.
// Depends on nothing; lecr_front, lecr_queue, lecr_back and the top import it.
`default_nettype none

package lecr_pkg;

   // Default size of the line store, counted with the terminating return.
   localparam int LINE_SIZE_DEF = 32;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Command letter slots: upper case first, then lower case.
   localparam int NUM_SLOTS  = 52;
   localparam int HALF_SLOTS = 26;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);

   // Character codes.
   localparam logic [7:0] CH_BS      = 8'd8;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_PCT     = 8'd37;
   localparam logic [7:0] CH_DEL     = 8'd127;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   // Result kinds as they appear on the result channel.
   typedef enum logic [1:0] {
      KIND_ECHO     = 2'd0,
      KIND_INVALID  = 2'd1,
      KIND_NOTFOUND = 2'd2,
      KIND_DISPATCH = 2'd3
   } kind_type;

   // Operations that the front hands to the back.
   typedef enum logic [1:0] {
      OP_REG,
      OP_ERASE,
      OP_CHAR,
      OP_RETURN
   } op_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] idx;
   } slot_type;

   typedef struct packed {
      op_type            op;
      logic [7:0]        ch;
      logic [3:0]        sid;
      logic [SLOT_W-1:0] slot;
   } cmd_type;

   // Maps a command letter to its slot; hit is low for any other character.
   function automatic slot_type slot_of(input logic [7:0] c);
      slot_type r;
      r.hit = 1'b0;
      r.idx = '0;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         r.hit = 1'b1;
         r.idx = SLOT_W'(c - CH_UPPER_A);
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         r.hit = 1'b1;
         r.idx = SLOT_W'(c - CH_LOWER_A) + SLOT_W'(HALF_SLOTS);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/lecr_req_if.sv
// Input channel of the line-edit command router: valid, ready and one
// keyboard character or registration. No dependencies.
`default_nettype none

interface lecr_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] char_in;
   logic [3:0] sender_id;

   modport source (output valid, output func, output char_in, output sender_id,
                   input ready);
   modport sink   (input valid, input func, input char_in, input sender_id,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/lecr_rsp_if.sv
// Result channel of the line-edit command router: valid, ready and one
// result item. No dependencies.
`default_nettype none

interface lecr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [3:0] dest_id;
   logic [7:0] char_out;
   logic       last;

   modport source (output valid, output kind, output dest_id, output char_out,
                   output last, input ready);
   modport sink   (input valid, input kind, input dest_id, input char_out,
                   input last, output ready);
endinterface

`default_nettype wire

>>> hdl/lecr_front.sv
// Front of the line-edit command router: accepts input items, classifies
// them and pushes commands into the queue. Uses lecr_pkg and lecr_req_if.
`default_nettype none

module lecr_front (
   lecr_req_if.sink        req_ch,
   output logic            push_valid,
   input  logic            push_ready,
   output lecr_pkg::cmd_type push_cmd
);
   import lecr_pkg::*;

   slot_type reg_slot;

   // A registration for a character that is not a letter is dropped here.
   assign reg_slot      = slot_of(req_ch.char_in);
   assign req_ch.ready  = push_ready;
   assign push_valid    = req_ch.valid && !(req_ch.func && !reg_slot.hit);

   // Classify the item into the operation that the back carries out.
   always_comb begin
      push_cmd.ch   = req_ch.char_in;
      push_cmd.sid  = req_ch.sender_id;
      push_cmd.slot = reg_slot.idx;
      if (req_ch.func) begin
         push_cmd.op = OP_REG;
      end else if (req_ch.char_in == CH_BS || req_ch.char_in == CH_DEL) begin
         push_cmd.op = OP_ERASE;
      end else if (req_ch.char_in == CH_CR) begin
         push_cmd.op = OP_RETURN;
      end else begin
         push_cmd.op = OP_CHAR;
      end
   end

endmodule

`default_nettype wire

>>> hdl/lecr_queue.sv
// Short command queue between the front and the back of the line-edit
// command router. Uses lecr_pkg for the entry type and the depth.
`default_nettype none

module lecr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  lecr_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output lecr_pkg::cmd_type pop_cmd
);
   import lecr_pkg::*;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

   cmd_type           slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign push_ready = (fill_ff != FILL_MAX);
   assign pop_valid  = (fill_ff != '0);
   assign pop_cmd    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> hdl/lecr_back.sv
// Back of the line-edit command router: edits the line store, keeps the
// route table and produces the result items. Uses lecr_pkg and lecr_rsp_if.
`default_nettype none

module lecr_back #(
   parameter int LINE_SIZE = lecr_pkg::LINE_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  lecr_pkg::cmd_type pop_cmd,
   lecr_rsp_if.source        rsp_ch
);
   import lecr_pkg::*;

   localparam int DEPTH = LINE_SIZE - 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(LINE_SIZE + 1);
   localparam logic [CNT_W-1:0] STORE_LIM = CNT_W'(LINE_SIZE - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(LINE_SIZE);
   localparam logic [1:0]       ECHO_END  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ECHO,
      ST_TAIL,
      ST_DISP
   } state_type;

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_INVALID,
      TAIL_NOTFOUND,
      TAIL_DISPATCH
   } tail_type;

   // Memories.
   logic [7:0] line_mem  [DEPTH];
   logic [3:0] route_mem [NUM_SLOTS];

   // Control state.
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [NUM_SLOTS-1:0] route_valid_ff, route_valid_in;
   logic                 out_valid_ff, out_valid_in;

   // Payload state.
   logic [7:0]       first_ch_ff, first_ch_in;
   logic [7:0]       second_ch_ff, second_ch_in;
   logic [7:0]       echo_ch_ff, echo_ch_in;
   logic             triple_ff, triple_in;
   logic [1:0]       echo_idx_ff, echo_idx_in;
   tail_type         tail_ff, tail_in;
   logic [CNT_W-1:0] disp_len_ff, disp_len_in;
   logic [IDX_W-1:0] disp_idx_ff, disp_idx_in;
   logic [7:0]       line_q_ff;
   logic [3:0]       id_q_ff;
   kind_type         out_kind_ff, out_kind_in;
   logic [3:0]       out_dest_ff, out_dest_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic             out_last_ff, out_last_in;

   // Memory access controls.
   logic             line_we;
   logic             route_we;
   logic             route_rd;

   // Decode helpers.
   logic             can_emit;
   logic             stored;
   logic             bad_line;
   logic             echo_done;
   logic             disp_end;
   logic [CNT_W-1:0] cnt_inc;
   logic [7:0]       eff_second;
   slot_type         sec_slot;

   assign pop_ready = (state_ff == ST_IDLE);
   assign can_emit  = !out_valid_ff || rsp_ch.ready;
   assign stored    = (count_ff < STORE_LIM);
   assign cnt_inc   = (count_ff < CNT_FULL) ? count_ff + CNT_W'(1) : count_ff;

   // With one character typed, the return itself becomes the command letter.
   assign eff_second = (count_ff == CNT_W'(1)) ? CH_CR : second_ch_ff;
   assign sec_slot   = slot_of(eff_second);
   assign bad_line   = !stored || (count_ff == '0) || (first_ch_ff != CH_PCT);

   assign echo_done  = !triple_ff || (echo_idx_ff == ECHO_END);
   assign disp_end   = (CNT_W'(disp_idx_ff) == disp_len_ff - CNT_W'(1));

   // Sequencer: take a command in idle, then emit its results in order.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      route_valid_in = route_valid_ff;
      first_ch_in    = first_ch_ff;
      second_ch_in   = second_ch_ff;
      echo_ch_in     = echo_ch_ff;
      triple_in      = triple_ff;
      echo_idx_in    = echo_idx_ff;
      tail_in        = tail_ff;
      disp_len_in    = disp_len_ff;
      disp_idx_in    = disp_idx_ff;
      out_valid_in   = out_valid_ff && !rsp_ch.ready;
      out_kind_in    = out_kind_ff;
      out_dest_in    = out_dest_ff;
      out_char_in    = out_char_ff;
      out_last_in    = out_last_ff;
      line_we        = 1'b0;
      route_we       = 1'b0;
      route_rd       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               echo_ch_in  = pop_cmd.ch;
               echo_idx_in = '0;
               triple_in   = 1'b0;
               tail_in     = TAIL_NONE;
               case (pop_cmd.op)
                  OP_REG: begin
                     route_we                     = 1'b1;
                     route_valid_in[pop_cmd.slot] = 1'b1;
                  end
                  OP_ERASE: begin
                     triple_in = (pop_cmd.ch == CH_BS) && (count_ff != '0);
                     if (count_ff != '0) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                     state_in = ST_ECHO;
                  end
                  OP_CHAR: begin
                     line_we = stored;
                     if (count_ff == '0) begin
                        first_ch_in = pop_cmd.ch;
                     end
                     if (count_ff == CNT_W'(1)) begin
                        second_ch_in = pop_cmd.ch;
                     end
                     count_in = cnt_inc;
                     state_in = ST_ECHO;
                  end
                  OP_RETURN: begin
                     line_we     = stored;
                     route_rd    = 1'b1;
                     count_in    = '0;
                     disp_len_in = count_ff + CNT_W'(1);
                     disp_idx_in = '0;
                     if (bad_line) begin
                        tail_in = TAIL_INVALID;
                     end else if (!sec_slot.hit) begin
                        tail_in = TAIL_NOTFOUND;
                     end else if (route_valid_ff[sec_slot.idx]) begin
                        tail_in = TAIL_DISPATCH;
                     end
                     state_in = ST_ECHO;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ECHO: begin
            if (can_emit) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_ECHO;
               out_dest_in  = '0;
               out_char_in  = (triple_ff && echo_idx_ff == 2'd1) ? CH_SPACE : echo_ch_ff;
               out_last_in  = echo_done && (tail_ff == TAIL_NONE);
               if (echo_done) begin
                  case (tail_ff)
                     TAIL_INVALID, TAIL_NOTFOUND: state_in = ST_TAIL;
                     TAIL_DISPATCH:               state_in = ST_DISP;
                     default:                     state_in = ST_IDLE;
                  endcase
               end else begin
                  echo_idx_in = echo_idx_ff + 2'd1;
               end
            end
         end
         ST_TAIL: begin
            if (can_emit) begin
               out_valid_in = 1'b1;
               out_kind_in  = (tail_ff == TAIL_INVALID) ? KIND_INVALID : KIND_NOTFOUND;
               out_dest_in  = '0;
               out_char_in  = '0;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DISP: begin
            if (can_emit) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_DISPATCH;
               out_dest_in  = id_q_ff;
               out_char_in  = line_q_ff;
               out_last_in  = disp_end;
               if (disp_end) begin
                  state_in = ST_IDLE;
               end else begin
                  disp_idx_in = disp_idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         route_valid_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         route_valid_ff <= route_valid_in;
         out_valid_ff   <= out_valid_in;
      end
      first_ch_ff  <= first_ch_in;
      second_ch_ff <= second_ch_in;
      echo_ch_ff   <= echo_ch_in;
      triple_ff    <= triple_in;
      echo_idx_ff  <= echo_idx_in;
      tail_ff      <= tail_in;
      disp_len_ff  <= disp_len_in;
      disp_idx_ff  <= disp_idx_in;
      out_kind_ff  <= out_kind_in;
      out_dest_ff  <= out_dest_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
   end

   // Line store. The read address follows the next dispatch index, so the
   // registered data always belongs to the current index.
   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[count_ff[IDX_W-1:0]] <= pop_cmd.ch;
      end
      line_q_ff <= line_mem[disp_idx_in];
   end

   // Route table ids; the valid bits live in flip-flops above.
   always_ff @(posedge clock) begin
      if (route_we) begin
         route_mem[pop_cmd.slot] <= pop_cmd.sid;
      end
      if (route_rd) begin
         id_q_ff <= route_mem[sec_slot.idx];
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.kind     = out_kind_ff;
   assign rsp_ch.dest_id  = out_dest_ff;
   assign rsp_ch.char_out = out_char_ff;
   assign rsp_ch.last     = out_last_ff;

endmodule

`default_nettype wire

>>> hdl/line_edit_command_router.sv
// Line-edit command router.
// req_ch carries keyboard characters (func low) and registrations of a
// requester id for a command letter (func high); rsp_ch carries the echo,
// the error codes and dispatched line characters, with last on the final
// result of each item. Both are valid/ready channels; a transfer happens
// on a clock edge with valid and ready high.
// A front classifies each item into a two-entry queue; a back works through
// one queued command at a time and holds its results in an output register.
// The back takes a command while idle, then emits its results in order:
// a plain key, a delete or an empty-line backspace gives its echo, a
// backspace with text echoes backspace, space, backspace, a registration
// gives none, and a return its echo, then an error code, nothing for an
// unregistered letter, or the dispatched line (up to LINE_SIZE-1 characters).
// When the receiver holds ready low, the output register keeps its result,
// the back waits, and the queue fills before req_ch drops ready.
// Synchronous reset empties the queue and the line and marks every command
// letter unregistered; it takes effect at once, with no clearing pass.
// Uses lecr_pkg, lecr_req_if, lecr_rsp_if, lecr_front, lecr_queue, lecr_back.
`default_nettype none

module line_edit_command_router #(
   parameter int LINE_SIZE = lecr_pkg::LINE_SIZE_DEF
) (
   input  logic     clock,
   input  logic     reset,
   lecr_req_if.sink   req_ch,
   lecr_rsp_if.source rsp_ch
);
   import lecr_pkg::*;

   logic    push_valid, push_ready;
   logic    pop_valid, pop_ready;
   cmd_type push_cmd, pop_cmd;

   // Classification of incoming items.
   lecr_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // Decoupling queue.
   lecr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // Line editing, routing and result generation.
   lecr_back #(
      .LINE_SIZE (LINE_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire
